/* hdl/stable_max_priority_queue_core_macros.svh */
// Assertion macros for the stable max priority queue core.
`ifndef STABLE_MAX_PRIORITY_QUEUE_CORE_MACROS_SVH
`define STABLE_MAX_PRIORITY_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SMPQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SMPQ_ASSERT_NORST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SMPQ_ASSERT(label, clk, rst_n, prop, msg)
`define SMPQ_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* hdl/smpq_pkg.sv */
// Types and constants shared by the priority queue modules.
`default_nettype none
package smpq_pkg;
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_STAMP = 2'd3
	} status_t;

	typedef struct packed {
		logic               op;
		logic signed [31:0] value;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] popped_value;
		logic signed [31:0] top_value;
		logic [8:0]         entry_count;
	} out_beat_t;

	typedef struct packed {
		logic [31:0] value;
		logic [31:0] stamp;
	} entry_t;

	localparam int ENTRY_W = 64;
	localparam logic [31:0] STAMP_LAST = 32'hFFFF_FFFF;

	// true when a outranks b
	function automatic logic outranks(entry_t a, entry_t b);
		logic [31:0] va;
		logic [31:0] vb;
		va = a.value ^ 32'h8000_0000;
		vb = b.value ^ 32'h8000_0000;
		if (va != vb)
			return va > vb;
		return a.stamp < b.stamp;
	endfunction
endpackage
`default_nettype wire

/* hdl/stable_max_priority_queue_core.sv */
// Top level of the stable max priority queue core.
//  channel | dir | handshake           | beat payload
//  in      | in  | in_valid/in_ready   | smpq_pkg::in_beat_t  (op, value)
//  out     | out | out_valid/out_ready | smpq_pkg::out_beat_t (status, popped, top, count)
// One beat in flight at a time. Each heap level costs one registered RAM read and one write-back.
// Push: accept cycle, then a parent read and a compare per level climbed, plus the root write if it
//   reaches the root or a parent read and the compare that stops it.
// Pop: accept, last-entry load, then a compare, plus a child read and a compare per level descended.
// Refused beats, a push into an empty heap and a pop down to empty finish in the accept cycle.
// Reset clears count, stamp, FSM and the result register; the RAM is never cleared.
// in_ready is low while busy or while a result waits; a result taken at the accept edge frees it.
`default_nettype none
`include "stable_max_priority_queue_core_macros.svh"
module stable_max_priority_queue_core #(
	parameter int HEAP_DEPTH = 256,
	localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1,
	localparam int CW = $clog2(HEAP_DEPTH + 1),
	localparam int XW = AW + 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire smpq_pkg::in_beat_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output smpq_pkg::out_beat_t       out_data
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_UPRD  = 7'b0000010, // parent read in flight
		S_UPCMP = 7'b0000100, // compare with parent
		S_UPFIN = 7'b0001000, // moving entry lands at the root
		S_LAST  = 7'b0010000, // last entry arrives, root children read
		S_DNRD  = 7'b0100000, // child reads in flight
		S_DNCMP = 7'b1000000  // compare with best child
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [31:0] stamp_q;
	logic [AW-1:0] pos_q;           // hole the moving entry sits over
	smpq_pkg::entry_t cur_q;        // moving entry held in registers
	logic [31:0] top_q;             // copy of the root value
	logic [31:0] popped_q;
	smpq_pkg::out_beat_t res_q;

	logic we;
	logic [AW-1:0] waddr, ra, rb;
	smpq_pkg::entry_t wdata, rda, rdb;

	logic out_free, acc;
	logic [AW-1:0] parent;
	logic [XW-1:0] lchild, rchild, count_x;
	logic [CW-1:0] cnt_m1;
	logic l_ok, r_ok, r_best, up_swap, dn_swap;
	smpq_pkg::entry_t best;
	logic [AW-1:0] best_idx;
	logic is_push, full, empty, stamp_end, push_ok, pop_ok;
	smpq_pkg::entry_t new_entry;
	logic done;
	logic [1:0] status_d;
	logic [31:0] popped_d;
	logic [CW-1:0] count_d;
	logic [31:0] top_d;

	smpq_ram #(.WIDTH(smpq_pkg::ENTRY_W), .DEPTH(HEAP_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr_a(ra), .rdata_a(rda), .raddr_b(rb), .rdata_b(rdb)
	);

	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign acc = in_valid && in_ready;

	// heap index arithmetic; children get two spare bits so the range check never wraps
	assign parent = (pos_q - AW'(1)) >> 1;
	assign lchild = {1'b0, pos_q, 1'b1};
	assign rchild = lchild + XW'(1);
	assign count_x = XW'(count_q);
	assign cnt_m1 = count_q - CW'(1);

	// children past the last entry are ignored
	assign l_ok = lchild < count_x;
	assign r_ok = rchild < count_x;
	assign r_best = r_ok && smpq_pkg::outranks(rdb, rda);
	assign best = r_best ? rdb : rda;
	assign best_idx = r_best ? rchild[AW-1:0] : lchild[AW-1:0];
	assign up_swap = smpq_pkg::outranks(cur_q, rda);
	assign dn_swap = l_ok && smpq_pkg::outranks(best, cur_q);

	// full is checked before stamp exhaustion
	assign is_push = in_data.op == smpq_pkg::OP_PUSH;
	assign full = count_q == CW'(HEAP_DEPTH);
	assign empty = count_q == '0;
	assign stamp_end = stamp_q == smpq_pkg::STAMP_LAST;
	assign push_ok = is_push && !full && !stamp_end;
	assign pop_ok = !is_push && !empty;
	assign new_entry = '{value: in_data.value, stamp: stamp_q};

	// read addresses; every read targets an entry not written at the same edge,
	// so no forwarding is needed
	always_comb begin
		ra = parent;
		rb = parent;
		case (state_q)
			S_IDLE: begin
				ra = cnt_m1[AW-1:0]; // last entry for a pop
				rb = cnt_m1[AW-1:0];
			end
			S_LAST, S_DNRD: begin
				ra = lchild[AW-1:0];
				rb = rchild[AW-1:0];
			end
			default: begin
				ra = parent;
				rb = parent;
			end
		endcase
	end

	// write-back: the parent or best child moves into the hole, or the moving entry lands
	always_comb begin
		we = 1'b0;
		waddr = pos_q;
		wdata = cur_q;
		case (state_q)
			S_IDLE: begin
				we = acc && push_ok && empty;
				waddr = '0;
				wdata = new_entry;
			end
			S_UPCMP: begin
				we = 1'b1;
				wdata = up_swap ? rda : cur_q;
			end
			S_UPFIN: we = 1'b1;
			S_DNCMP: begin
				we = 1'b1;
				wdata = dn_swap ? best : cur_q;
			end
			default: ;
		endcase
	end

	// result fields for the cycle in which the beat finishes
	always_comb begin
		done = 1'b0;
		status_d = smpq_pkg::ST_OK;
		popped_d = popped_q;
		count_d = count_q;
		case (state_q)
			S_IDLE: begin
				if (is_push) begin
					if (full)
						status_d = smpq_pkg::ST_FULL;
					else if (stamp_end)
						status_d = smpq_pkg::ST_STAMP;
				end else if (empty) begin
					status_d = smpq_pkg::ST_EMPTY;
				end
				popped_d = pop_ok ? top_q : 32'd0;
				if (push_ok)
					count_d = count_q + CW'(1);
				else if (pop_ok)
					count_d = cnt_m1;
				done = acc && (!(push_ok || pop_ok) || (push_ok && empty)
					|| (pop_ok && cnt_m1 == '0));
			end
			S_UPCMP: done = !up_swap;
			S_UPFIN: done = 1'b1;
			S_DNCMP: done = !dn_swap;
			default: ;
		endcase
	end

	// root value after this cycle's write
	assign top_d = (count_d == '0) ? 32'd0 : ((we && waddr == '0) ? wdata.value : top_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			stamp_q <= '0;
			out_valid <= 1'b0;
			res_q <= '0;
		end else begin
			if (done) begin
				out_valid <= 1'b1;
				res_q <= '{status: status_d, popped_value: popped_d, top_value: top_d,
					entry_count: 9'(count_d)};
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (acc) begin
					count_q <= count_d;
					if (push_ok) begin
						stamp_q <= stamp_q + 32'd1;
						state_q <= empty ? S_IDLE : S_UPRD;
					end else if (pop_ok) begin
						state_q <= (cnt_m1 == '0) ? S_IDLE : S_LAST;
					end
				end
				S_UPRD: state_q <= S_UPCMP;
				S_UPCMP: begin
					if (!up_swap)
						state_q <= S_IDLE;
					else if (parent == '0)
						state_q <= S_UPFIN;
					else
						state_q <= S_UPRD;
				end
				S_UPFIN: state_q <= S_IDLE;
				S_LAST: state_q <= S_DNCMP;
				S_DNRD: state_q <= S_DNCMP;
				S_DNCMP: state_q <= dn_swap ? S_DNRD : S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we && waddr == '0)
			top_q <= wdata.value;
		case (state_q)
			S_IDLE: if (acc) begin
				popped_q <= popped_d;
				cur_q <= new_entry;
				pos_q <= push_ok ? count_q[AW-1:0] : '0;
			end
			S_UPCMP: if (up_swap) pos_q <= parent;
			S_LAST: cur_q <= rda;
			S_DNCMP: if (dn_swap) pos_q <= best_idx;
			default: ;
		endcase
	end

	assign out_data = res_q;

	`SMPQ_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result beat changed while waiting")
	`SMPQ_ASSERT(a_state_onehot, clk, arst_n, $onehot(state_q), "state not one-hot")
	`SMPQ_ASSERT(a_count_range, clk, arst_n, count_q <= CW'(HEAP_DEPTH), "count past depth")
	`SMPQ_ASSERT(a_busy_no_ready, clk, arst_n, state_q != S_IDLE |-> !in_ready, "ready while busy")
	`SMPQ_ASSERT_NORST(a_rst_quiet, clk, !arst_n |-> !out_valid, "out_valid during reset")
endmodule
`default_nettype wire

/* hdl/smpq_ram.sv */
// Generic single-port-write, dual-port-read RAM with registered read data.
`default_nettype none
module smpq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr_a,
	output logic      [WIDTH-1:0] rdata_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the stable max priority queue core.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	localparam int DEPTH      = 256;
	localparam int RAND_BEATS = 760;
	localparam int STALL_MAX  = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	smpq_pkg::in_beat_t in_data;
	logic out_valid;
	logic out_ready;
	smpq_pkg::out_beat_t out_data;

	stable_max_priority_queue_core #(.HEAP_DEPTH(DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow heap: values and arrival stamps, plus entry count and next stamp.
	logic signed [31:0] heap_val [DEPTH];
	logic [31:0]        heap_stamp [DEPTH];
	int unsigned        heap_cnt;
	logic [31:0]        stamp_next;

	smpq_pkg::out_beat_t result_q[$];
	int  fail_cnt;
	int  stall_cnt;
	int  push_cnt, pop_cnt, refuse_cnt, result_cnt;
	bit  calm;	// long stretch with no idling on either side

	// larger value wins; equal values go by earlier stamp
	function automatic bit ranks_above(int unsigned a, int unsigned b);
		if (heap_val[a] != heap_val[b])
			return heap_val[a] > heap_val[b];
		return heap_stamp[a] < heap_stamp[b];
	endfunction

	function automatic void swap_slots(int unsigned a, int unsigned b);
		logic signed [31:0] v;
		logic [31:0] s;
		v = heap_val[a]; s = heap_stamp[a];
		heap_val[a] = heap_val[b]; heap_stamp[a] = heap_stamp[b];
		heap_val[b] = v; heap_stamp[b] = s;
	endfunction

	function automatic smpq_pkg::out_beat_t heap_step(smpq_pkg::in_beat_t b);
		smpq_pkg::out_beat_t r;
		int unsigned pos, par, lc, best;
		r = '0;
		r.status = smpq_pkg::ST_OK;
		if (b.op == smpq_pkg::OP_PUSH) begin
			if (heap_cnt >= DEPTH) begin
				r.status = smpq_pkg::ST_FULL;
			end else if (stamp_next == smpq_pkg::STAMP_LAST) begin
				r.status = smpq_pkg::ST_STAMP;
			end else begin
				pos = heap_cnt;
				heap_val[pos] = b.value;
				heap_stamp[pos] = stamp_next;
				stamp_next++;
				heap_cnt++;
				while (pos > 0) begin
					par = (pos - 1) / 2;
					if (!ranks_above(pos, par))
						break;
					swap_slots(pos, par);
					pos = par;
				end
			end
		end else begin
			if (heap_cnt == 0) begin
				r.status = smpq_pkg::ST_EMPTY;
			end else begin
				r.popped_value = heap_val[0];
				heap_cnt--;
				if (heap_cnt > 0) begin
					heap_val[0] = heap_val[heap_cnt];
					heap_stamp[0] = heap_stamp[heap_cnt];
					pos = 0;
					forever begin
						lc = 2 * pos + 1;
						if (lc >= heap_cnt)
							break;
						best = lc;
						if (lc + 1 < heap_cnt && ranks_above(lc + 1, lc))
							best = lc + 1;
						if (!ranks_above(best, pos))
							break;
						swap_slots(pos, best);
						pos = best;
					end
				end
			end
		end
		r.top_value = (heap_cnt > 0) ? heap_val[0] : 32'sd0;
		r.entry_count = heap_cnt[8:0];
		return r;
	endfunction

	// Send one beat; random idle gap first. Valid stays high after the beat is taken
	// so that the next beat can follow without a second update in the same step.
	task automatic send_beat(logic op, logic signed [31:0] v);
		while (!calm && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{op: op, value: v};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		result_q.push_back(heap_step('{op: op, value: v}));
		if (op == smpq_pkg::OP_PUSH) push_cnt++; else pop_cnt++;
	endtask

	// Random value: mostly a narrow band so equal values (stamp order) show up.
	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(3))
			0: return $signed($urandom());
			1: return $signed($urandom_range(8)) - 4;
			2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $signed($urandom_range(40)) - 20;
		endcase
	endfunction

	// Receiver: random back-pressure, checks against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		smpq_pkg::out_beat_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				result_cnt++;
				if (result_q.size() == 0) begin
					$error("unexpected result beat %p", out_data);
					fail_cnt++;
				end else begin
					want = result_q.pop_front();
					if (want.status != smpq_pkg::ST_OK) refuse_cnt++;
					if (out_data.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_data.status);
						fail_cnt++;
					end
					if (out_data.popped_value !== want.popped_value) begin
						$error("popped_value: expected %0d, got %0d",
							want.popped_value, out_data.popped_value);
						fail_cnt++;
					end
					if (out_data.top_value !== want.top_value) begin
						$error("top_value: expected %0d, got %0d",
							want.top_value, out_data.top_value);
						fail_cnt++;
					end
					if (out_data.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, out_data.entry_count);
						fail_cnt++;
					end
				end
			end
			out_ready <= calm || ($urandom_range(99) >= 16);
		end
	end

	// Watchdog: cycles with no beat accepted on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_MAX) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic drain();
		in_valid <= 1'b0;
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Directed table: op, value, expected result where obvious, check flag.
	typedef struct {
		logic                op;
		logic signed [31:0]  v;
		bit                  fixed;
		smpq_pkg::out_beat_t exp_r;
	} row_t;

	row_t rows[$];
	smpq_pkg::out_beat_t got_r;

	initial begin
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		fail_cnt = 0; stall_cnt = 0;
		push_cnt = 0; pop_cnt = 0; refuse_cnt = 0; result_cnt = 0;
		heap_cnt = 0; stamp_next = '0;
		calm = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pop on empty heap, then extremes, equal values and pop-back
		rows = '{
			'{smpq_pkg::OP_POP,  32'sd5,         1, '{smpq_pkg::ST_EMPTY, 0, 0, 0}},
			'{smpq_pkg::OP_PUSH, 32'sh8000_0000, 1,
				'{smpq_pkg::ST_OK, 0, 32'sh8000_0000, 1}},
			'{smpq_pkg::OP_PUSH, 32'sh7FFF_FFFF, 1,
				'{smpq_pkg::ST_OK, 0, 32'sh7FFF_FFFF, 2}},
			'{smpq_pkg::OP_PUSH, 32'sd0,         0, '0},
			'{smpq_pkg::OP_PUSH, -32'sd1,        0, '0},
			'{smpq_pkg::OP_PUSH, 32'sd7,         0, '0},
			'{smpq_pkg::OP_PUSH, 32'sd7,         0, '0},
			'{smpq_pkg::OP_PUSH, 32'sd7,         0, '0},
			'{smpq_pkg::OP_PUSH, 32'sh7FFF_FFFF, 0, '0},
			'{smpq_pkg::OP_POP,  32'shFFFF_FFFF, 1,
				'{smpq_pkg::ST_OK, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 7}},
			'{smpq_pkg::OP_POP,  32'sd0,         0, '0},
			'{smpq_pkg::OP_POP,  32'sd0,         0, '0},
			'{smpq_pkg::OP_POP,  32'sd0,         0, '0},
			'{smpq_pkg::OP_POP,  32'sd0,         0, '0},
			'{smpq_pkg::OP_POP,  32'sd0,         0, '0},
			'{smpq_pkg::OP_POP,  32'sd0,         0, '0},
			'{smpq_pkg::OP_POP,  32'sd0,         1,
				'{smpq_pkg::ST_OK, 32'sh8000_0000, 0, 0}},
			'{smpq_pkg::OP_POP,  32'sd0,         1, '{smpq_pkg::ST_EMPTY, 0, 0, 0}}
		};
		foreach (rows[i]) begin
			send_beat(rows[i].op, rows[i].v);
			if (rows[i].fixed) begin
				got_r = result_q[$];
				if (got_r !== rows[i].exp_r) begin
					$error("row %0d: table %p, predictor %p", i, rows[i].exp_r, got_r);
					fail_cnt++;
				end
			end
		end

		// fill to full, probe refusal, then empty it: sender waits for results
		drain();
		for (int i = 0; i < DEPTH; i++)
			send_beat(smpq_pkg::OP_PUSH, rand_value());
		send_beat(smpq_pkg::OP_PUSH, 32'sd1);
		drain();
		for (int i = 0; i < DEPTH + 1; i++)
			send_beat(smpq_pkg::OP_POP, $signed($urandom()));
		drain();

		// random mix, drifting between push-heavy and pop-heavy phases
		n = 0;
		while (n < RAND_BEATS) begin
			int push_pct;
			push_pct = $urandom_range(1) ? 70 : 35;
			calm = (n >= 400 && n < 600);
			repeat ($urandom_range(150, 20)) begin
				if (n < RAND_BEATS) begin
					if ($urandom_range(99) < push_pct)
						send_beat(smpq_pkg::OP_PUSH, rand_value());
					else
						send_beat(smpq_pkg::OP_POP, $signed($urandom()));
					n++;
				end
			end
		end
		calm = 1'b0;
		drain();

		$display("tb_top: %0d pushes, %0d pops, %0d results, %0d refused (full/empty)",
			push_cnt, pop_cnt, result_cnt, refuse_cnt);
		$display("tb_top: stamp-overflow refusal not reachable in a run of this length");
		if (fail_cnt == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+hdl
hdl/smpq_pkg.sv
hdl/smpq_ram.sv
hdl/stable_max_priority_queue_core.sv
sim/tb_top.sv
